### rtl/selection_mask_cell_classifier_top_defines.svh
// Assertion macros used by the classifier back end (smcc_back).
`ifndef SELECTION_MASK_CELL_CLASSIFIER_TOP_DEFINES_SVH
`define SELECTION_MASK_CELL_CLASSIFIER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SMCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the following cycle.
`define SMCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/smcc_pkg.sv
package smcc_pkg;

	// Field widths
	localparam int COORD_BITS_DEF = 12;
	localparam int SEL_W  = 11;
	localparam int DIM_W  = 11;
	localparam int PIX_W  = 8;
	localparam int MAG_W  = 11;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int PROD_W = 2 * SQ_W;
	localparam int SUM_W  = PROD_W + 1;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [DIM_W-1:0] GRID_RESET = 11'd1024;

	typedef enum logic [2:0] {
		REG_SEL_LEFT      = 3'd0,
		REG_SEL_TOP       = 3'd1,
		REG_SEL_WIDTH     = 3'd2,
		REG_SEL_HEIGHT    = 3'd3,
		REG_SHAPE_ELLIPSE = 3'd4,
		REG_GRID_COLS     = 3'd5,
		REG_GRID_ROWS     = 3'd6,
		REG_TRANSPARENT   = 3'd7
	} reg_idx_t;

	// Register file contents as seen by the datapath
	typedef struct packed {
		logic [SEL_W-1:0] sel_left;
		logic [SEL_W-1:0] sel_top;
		logic [DIM_W-1:0] sel_width;
		logic [DIM_W-1:0] sel_height;
		logic             shape_ellipse;
		logic [DIM_W-1:0] grid_cols;
		logic [DIM_W-1:0] grid_rows;
		logic [PIX_W-1:0] transparent_value;
	} cfg_t;

	// Stage 1: box and grid tests, centred offsets
	typedef struct packed {
		logic             in_box;
		logic             in_grid;
		logic             ell_en;
		logic [MAG_W-1:0] dx_mag;
		logic [MAG_W-1:0] dy_mag;
		logic [DIM_W-1:0] a;
		logic [DIM_W-1:0] b;
		logic [PIX_W-1:0] pixel;
	} s1_t;

	// Stage 2: squares
	typedef struct packed {
		logic            in_box;
		logic            in_grid;
		logic            ell_en;
		logic [SQ_W-1:0] dx2;
		logic [SQ_W-1:0] dy2;
		logic [SQ_W-1:0] a2;
		logic [SQ_W-1:0] b2;
		logic [PIX_W-1:0] pixel;
	} s2_t;

	// Stage 3: cross products
	typedef struct packed {
		logic              in_box;
		logic              in_grid;
		logic              ell_en;
		logic [PROD_W-1:0] term_x;
		logic [PROD_W-1:0] term_y;
		logic [PROD_W-1:0] bound;
		logic [PIX_W-1:0]  pixel;
	} s3_t;

endpackage

### rtl/smcc_if.sv
// Cell channel: one coordinate and the pixel at it
interface smcc_cell_if #(
	parameter int COORD_BITS = smcc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] cell_col;
	logic signed [COORD_BITS-1:0] cell_row;
	logic [smcc_pkg::PIX_W-1:0]   pixel_value;

	modport source (output valid, cell_col, cell_row, pixel_value, input ready);
	modport sink (input valid, cell_col, cell_row, pixel_value, output ready);
endinterface

// Result channel: classification of one cell
interface smcc_result_if;
	logic                       valid;
	logic                       ready;
	logic                       in_selection;
	logic                       in_mask;
	logic [smcc_pkg::PIX_W-1:0] clip_value;
	logic                       clear_change;

	modport source (output valid, in_selection, in_mask, clip_value, clear_change,
		input ready);
	modport sink (input valid, in_selection, in_mask, clip_value, clear_change,
		output ready);
endinterface

### rtl/smcc_cfg.sv
module smcc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smcc_pkg::ADDR_W-1:0]   paddr,
	input  logic [smcc_pkg::DATA_W-1:0]   pwdata,
	output logic [smcc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output smcc_pkg::cfg_t                cfg
);

	smcc_pkg::cfg_t   cfg_q;
	smcc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = smcc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write a register on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sel_left          <= '0;
			cfg_q.sel_top           <= '0;
			cfg_q.sel_width         <= '0;
			cfg_q.sel_height        <= '0;
			cfg_q.shape_ellipse     <= 1'b0;
			cfg_q.grid_cols         <= smcc_pkg::GRID_RESET;
			cfg_q.grid_rows         <= smcc_pkg::GRID_RESET;
			cfg_q.transparent_value <= '0;
		end else if (wr_en) begin
			unique case (idx)
				smcc_pkg::REG_SEL_LEFT:      cfg_q.sel_left <= pwdata[smcc_pkg::SEL_W-1:0];
				smcc_pkg::REG_SEL_TOP:       cfg_q.sel_top <= pwdata[smcc_pkg::SEL_W-1:0];
				smcc_pkg::REG_SEL_WIDTH:     cfg_q.sel_width <= pwdata[smcc_pkg::DIM_W-1:0];
				smcc_pkg::REG_SEL_HEIGHT:    cfg_q.sel_height <= pwdata[smcc_pkg::DIM_W-1:0];
				smcc_pkg::REG_SHAPE_ELLIPSE: cfg_q.shape_ellipse <= pwdata[0];
				smcc_pkg::REG_GRID_COLS:     cfg_q.grid_cols <= pwdata[smcc_pkg::DIM_W-1:0];
				smcc_pkg::REG_GRID_ROWS:     cfg_q.grid_rows <= pwdata[smcc_pkg::DIM_W-1:0];
				smcc_pkg::REG_TRANSPARENT:
					cfg_q.transparent_value <= pwdata[smcc_pkg::PIX_W-1:0];
			endcase
		end
	end

	// Return the addressed register, zero-filled
	always_comb begin
		unique case (idx)
			smcc_pkg::REG_SEL_LEFT:      prdata = smcc_pkg::DATA_W'(cfg_q.sel_left);
			smcc_pkg::REG_SEL_TOP:       prdata = smcc_pkg::DATA_W'(cfg_q.sel_top);
			smcc_pkg::REG_SEL_WIDTH:     prdata = smcc_pkg::DATA_W'(cfg_q.sel_width);
			smcc_pkg::REG_SEL_HEIGHT:    prdata = smcc_pkg::DATA_W'(cfg_q.sel_height);
			smcc_pkg::REG_SHAPE_ELLIPSE: prdata = smcc_pkg::DATA_W'(cfg_q.shape_ellipse);
			smcc_pkg::REG_GRID_COLS:     prdata = smcc_pkg::DATA_W'(cfg_q.grid_cols);
			smcc_pkg::REG_GRID_ROWS:     prdata = smcc_pkg::DATA_W'(cfg_q.grid_rows);
			smcc_pkg::REG_TRANSPARENT:   prdata = smcc_pkg::DATA_W'(cfg_q.transparent_value);
		endcase
	end

endmodule

### rtl/smcc_front.sv
module smcc_front #(
	parameter int COORD_BITS = smcc_pkg::COORD_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  smcc_pkg::cfg_t  cfg,
	smcc_cell_if.sink       cell_rx,
	input  logic            ready_s2,
	output logic            valid_s1,
	output smcc_pkg::s1_t   data_s1
);

	// Wide enough for any coordinate, corner and far edge of the box
	localparam int DW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;

	logic signed [DW-1:0] col_x, row_x, left_x, top_x, w_x, h_x, gc_x, gr_x;
	logic signed [DW-1:0] d_col, d_row;
	logic [smcc_pkg::DIM_W-1:0] a, b;
	logic signed [12:0] dx, dy, dx_neg, dy_neg;
	logic ready_s1;
	smcc_pkg::s1_t next_s1;

	assign col_x  = DW'(cell_rx.cell_col);
	assign row_x  = DW'(cell_rx.cell_row);
	assign left_x = DW'($signed(cfg.sel_left));
	assign top_x  = DW'($signed(cfg.sel_top));
	assign w_x    = $signed(DW'(cfg.sel_width));
	assign h_x    = $signed(DW'(cfg.sel_height));
	assign gc_x   = $signed(DW'(cfg.grid_cols));
	assign gr_x   = $signed(DW'(cfg.grid_rows));
	assign d_col  = col_x - left_x;
	assign d_row  = row_x - top_x;
	assign a      = cfg.sel_width - 11'd1;
	assign b      = cfg.sel_height - 11'd1;

	// Centre the offsets on doubled coordinates; only meaningful inside the box
	assign dx     = $signed({1'b0, d_col[10:0], 1'b0}) - $signed({2'b00, a});
	assign dy     = $signed({1'b0, d_row[10:0], 1'b0}) - $signed({2'b00, b});
	assign dx_neg = -dx;
	assign dy_neg = -dy;

	always_comb begin
		next_s1.in_box  = (col_x >= left_x) && (row_x >= top_x) &&
			(col_x < left_x + w_x) && (row_x < top_x + h_x);
		next_s1.in_grid = !col_x[DW-1] && !row_x[DW-1] && (col_x < gc_x) && (row_x < gr_x);
		next_s1.ell_en  = cfg.shape_ellipse && (cfg.sel_width > 11'd1) &&
			(cfg.sel_height > 11'd1);
		next_s1.dx_mag  = dx[12] ? dx_neg[10:0] : dx[10:0];
		next_s1.dy_mag  = dy[12] ? dy_neg[10:0] : dy[10:0];
		next_s1.a       = a;
		next_s1.b       = b;
		next_s1.pixel   = cell_rx.pixel_value;
	end

	// Take a transfer when the stage is empty or drains this cycle
	assign ready_s1      = !valid_s1 || ready_s2;
	assign cell_rx.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= cell_rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && cell_rx.valid) begin
			data_s1 <= next_s1;
		end
	end

endmodule

### rtl/smcc_ellipse.sv
module smcc_ellipse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  smcc_pkg::s1_t data_s1,
	output logic          ready_s2,
	input  logic          ready_s4,
	output logic          valid_s3,
	output smcc_pkg::s3_t data_s3
);

	logic          valid_s2;
	smcc_pkg::s2_t data_s2;
	logic          ready_s3;

	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s3 = !valid_s3 || ready_s4;

	// Square offsets and semi-axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.in_box  <= data_s1.in_box;
			data_s2.in_grid <= data_s1.in_grid;
			data_s2.ell_en  <= data_s1.ell_en;
			data_s2.dx2     <= {11'b0, data_s1.dx_mag} * {11'b0, data_s1.dx_mag};
			data_s2.dy2     <= {11'b0, data_s1.dy_mag} * {11'b0, data_s1.dy_mag};
			data_s2.a2      <= {11'b0, data_s1.a} * {11'b0, data_s1.a};
			data_s2.b2      <= {11'b0, data_s1.b} * {11'b0, data_s1.b};
			data_s2.pixel   <= data_s1.pixel;
		end
	end

	// Form dx^2*b^2, dy^2*a^2 and the bound a^2*b^2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			data_s3.in_box  <= data_s2.in_box;
			data_s3.in_grid <= data_s2.in_grid;
			data_s3.ell_en  <= data_s2.ell_en;
			data_s3.term_x  <= {22'b0, data_s2.dx2} * {22'b0, data_s2.b2};
			data_s3.term_y  <= {22'b0, data_s2.dy2} * {22'b0, data_s2.a2};
			data_s3.bound   <= {22'b0, data_s2.a2} * {22'b0, data_s2.b2};
			data_s3.pixel   <= data_s2.pixel;
		end
	end

endmodule

### rtl/smcc_back.sv
`include "selection_mask_cell_classifier_top_defines.svh"

module smcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  smcc_pkg::cfg_t cfg,
	input  logic          valid_s3,
	input  smcc_pkg::s3_t data_s3,
	output logic          ready_s4,
	smcc_result_if.source result
);

	logic [smcc_pkg::SUM_W-1:0] lhs;
	logic ell_in, sel, mask;
	logic valid_s4;

	assign lhs    = {1'b0, data_s3.term_x} + {1'b0, data_s3.term_y};
	assign ell_in = lhs <= {1'b0, data_s3.bound};
	assign sel    = data_s3.in_box && (!data_s3.ell_en || ell_in);
	assign mask   = sel && data_s3.in_grid;

	// Output register: hold the result until the sink takes it
	assign ready_s4     = !valid_s4 || result.ready;
	assign result.valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			result.in_selection <= sel;
			result.in_mask      <= mask;
			result.clip_value   <= mask ? data_s3.pixel : cfg.transparent_value;
			result.clear_change <= mask && (data_s3.pixel != cfg.transparent_value);
		end
	end

	`SMCC_ASSERT_IMPLY(a_mask_in_sel, clk, arst_n,
		result.valid && result.in_mask, result.in_selection, "mask set outside selection")
	`SMCC_ASSERT_IMPLY(a_clip_trans, clk, arst_n,
		result.valid && !result.in_mask, result.clip_value == cfg.transparent_value,
		"clip value not transparent outside mask")
	`SMCC_ASSERT_NEXT(a_box_gate, clk, arst_n,
		valid_s3 && ready_s4 && !data_s3.in_box, !result.in_selection,
		"cell outside box reported as selected")

endmodule

### rtl/selection_mask_cell_classifier_top.sv
// Selection mask cell classifier. One cell (column, row, pixel) enters and one
// classification leaves per clock while the result sink is ready, each result passing
// four register stages: box and grid compares, squaring of the centred offsets and
// semi-axes, the two cross products, then the ellipse sum and compare into the output
// register. Every stage stalls on its own, so a waiting result does not stop new cells
// filling empty stages. Registers are to be written over the APB port while no cell is in
// flight (the block does not enforce this); they take effect for the next cell accepted.
module selection_mask_cell_classifier_top #(
	parameter int COORD_BITS = smcc_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smcc_pkg::ADDR_W-1:0] paddr,
	input  logic [smcc_pkg::DATA_W-1:0] pwdata,
	output logic [smcc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	smcc_cell_if.sink                   cell_in,
	smcc_result_if.source               result_out
);

	smcc_pkg::cfg_t cfg;
	logic           valid_s1, ready_s2, valid_s3, ready_s4;
	smcc_pkg::s1_t  data_s1;
	smcc_pkg::s3_t  data_s3;

	smcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smcc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cell_rx  (cell_in),
		.ready_s2 (ready_s2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	smcc_ellipse u_ellipse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ready_s2 (ready_s2),
		.ready_s4 (ready_s4),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	smcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.ready_s4 (ready_s4),
		.result   (result_out)
	);

endmodule

### sim/selection_mask_cell_classifier_checker.sv
module selection_mask_cell_classifier_checker
	import smcc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	smcc_cell_if              cell_ch,
	smcc_result_if            result_ch,
	output int                fail_count,
	output int                pending_count,
	output int                checked_count,
	output int                mask_count
);

	typedef struct packed {
		logic             in_selection;
		logic             in_mask;
		logic [PIX_W-1:0] clip_value;
		logic             clear_change;
	} cell_verdict_t;

	// Shadow of the register file, updated from the APB writes seen on the bus
	logic signed [SEL_W-1:0] cfg_left;
	logic signed [SEL_W-1:0] cfg_top;
	logic [DIM_W-1:0]        cfg_width;
	logic [DIM_W-1:0]        cfg_height;
	logic                    cfg_ellipse;
	logic [DIM_W-1:0]        cfg_cols;
	logic [DIM_W-1:0]        cfg_rows;
	logic [PIX_W-1:0]        cfg_trans;

	// Classifications owed by the block, oldest first
	cell_verdict_t verdict_q[$];
	cell_verdict_t want;

	// Classify one cell against the box, the ellipse and the grid bounds
	function automatic cell_verdict_t classify_cell(input logic signed [COORD_BITS-1:0] col_in,
			input logic signed [COORD_BITS-1:0] row_in, input logic [PIX_W-1:0] pix);
		longint col, row, left, top, wid, hgt, cols, rows, a, b, dx, dy;
		bit in_sel, in_msk;
		cell_verdict_t v;
		col = col_in;
		row = row_in;
		left = cfg_left;
		top = cfg_top;
		wid = cfg_width;
		hgt = cfg_height;
		cols = cfg_cols;
		rows = cfg_rows;
		in_sel = col >= left && row >= top && col < left + wid && row < top + hgt;
		// thin ellipses fall back to the box test
		if (in_sel && cfg_ellipse) begin
			a = wid - 1;
			b = hgt - 1;
			if (a > 0 && b > 0) begin
				dx = 2 * (col - left) - a;
				dy = 2 * (row - top) - b;
				in_sel = dx * dx * b * b + dy * dy * a * a <= a * a * b * b;
			end
		end
		in_msk = in_sel && col >= 0 && row >= 0 && col < cols && row < rows;
		v.in_selection = in_sel;
		v.in_mask = in_msk;
		v.clip_value = in_msk ? pix : cfg_trans;
		v.clear_change = in_msk && pix != cfg_trans;
		return v;
	endfunction

	task automatic check_field(input string field, input logic [PIX_W-1:0] exp_val,
			input logic [PIX_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_left = '0;
			cfg_top = '0;
			cfg_width = '0;
			cfg_height = '0;
			cfg_ellipse = 1'b0;
			cfg_cols = GRID_RESET;
			cfg_rows = GRID_RESET;
			cfg_trans = '0;
			verdict_q.delete();
			fail_count = 0;
			pending_count = 0;
			checked_count = 0;
			mask_count = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_SEL_LEFT:      cfg_left = pwdata[SEL_W-1:0];
					REG_SEL_TOP:       cfg_top = pwdata[SEL_W-1:0];
					REG_SEL_WIDTH:     cfg_width = pwdata[DIM_W-1:0];
					REG_SEL_HEIGHT:    cfg_height = pwdata[DIM_W-1:0];
					REG_SHAPE_ELLIPSE: cfg_ellipse = pwdata[0];
					REG_GRID_COLS:     cfg_cols = pwdata[DIM_W-1:0];
					REG_GRID_ROWS:     cfg_rows = pwdata[DIM_W-1:0];
					REG_TRANSPARENT:   cfg_trans = pwdata[PIX_W-1:0];
					default: ;
				endcase
			end
			// compare each result transfer with the oldest classification owed
			if (result_ch.valid && result_ch.ready) begin
				checked_count++;
				if (verdict_q.size() == 0) begin
					$error("result transfer with no classification outstanding");
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (want.in_mask)
						mask_count++;
					check_field("in_selection", want.in_selection, result_ch.in_selection);
					check_field("in_mask", want.in_mask, result_ch.in_mask);
					check_field("clip_value", want.clip_value, result_ch.clip_value);
					check_field("clear_change", want.clear_change, result_ch.clear_change);
				end
			end
			// queue the classification of each cell transfer
			if (cell_ch.valid && cell_ch.ready)
				verdict_q.insert(verdict_q.size(), classify_cell(cell_ch.cell_col,
					cell_ch.cell_row, cell_ch.pixel_value));
			pending_count = verdict_q.size();
		end
	end

endmodule

### sim/selection_mask_cell_classifier_top_tb.sv
module selection_mask_cell_classifier_top_tb;
	import smcc_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int COORD_MIN = -(1 << (CB - 1));
	localparam int COORD_MAX = (1 << (CB - 1)) - 1;
	localparam int PIPE_DEPTH = 4;
	localparam int DRAIN_CYCLES = 3 * PIPE_DEPTH;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_CELLS = 110;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	smcc_cell_if #(.COORD_BITS(CB)) cell_ch();
	smcc_result_if                  result_ch();

	int fail_count;
	int pending_count;
	int checked_count;
	int mask_count;

	// Selection currently programmed, used to aim the random cells
	int         cur_left;
	int         cur_top;
	int         cur_width;
	int         cur_height;
	int         cur_cols;
	int         cur_rows;
	logic [7:0] cur_trans;

	int burst_left;
	bit steady_flow;
	bit long_hold_armed;
	bit long_hold_done;
	int cells_sent;
	int settings_used;

	selection_mask_cell_classifier_top #(.COORD_BITS(CB)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cell_in    (cell_ch),
		.result_out (result_ch)
	);

	selection_mask_cell_classifier_checker #(.COORD_BITS(CB)) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.cell_ch       (cell_ch),
		.result_ch     (result_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.mask_count    (mask_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// APB write: setup cycle, access cycle, then release the bus
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_selection(input int left, input int top, input int width,
			input int height, input int ellipse, input int cols, input int rows, input int trans);
		cur_left = left;
		cur_top = top;
		cur_width = width;
		cur_height = height;
		cur_cols = cols;
		cur_rows = rows;
		cur_trans = trans[7:0];
		write_reg(REG_SEL_LEFT, 32'(left[SEL_W-1:0]));
		write_reg(REG_SEL_TOP, 32'(top[SEL_W-1:0]));
		write_reg(REG_SEL_WIDTH, 32'(width[DIM_W-1:0]));
		write_reg(REG_SEL_HEIGHT, 32'(height[DIM_W-1:0]));
		write_reg(REG_SHAPE_ELLIPSE, 32'(ellipse[0]));
		write_reg(REG_GRID_COLS, 32'(cols[DIM_W-1:0]));
		write_reg(REG_GRID_ROWS, 32'(rows[DIM_W-1:0]));
		write_reg(REG_TRANSPARENT, 32'(trans[PIX_W-1:0]));
		settings_used++;
	endtask

	// Offer one cell, in bursts with random gaps unless the flow is steady
	task automatic send_cell(input int col, input int row, input int pix);
		int gap;
		if (!steady_flow && burst_left <= 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				cell_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cell_ch.valid <= 1'b1;
		cell_ch.cell_col <= col[CB-1:0];
		cell_ch.cell_row <= row[CB-1:0];
		cell_ch.pixel_value <= pix[7:0];
		do @(posedge clk); while (!cell_ch.ready);
		cells_sent++;
		@(negedge clk);
	endtask

	// Hold the input idle until every classification has come back
	task automatic settle();
		cell_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int clamp_coord(input int v);
		return v < COORD_MIN ? COORD_MIN : (v > COORD_MAX ? COORD_MAX : v);
	endfunction

	function automatic int pick_origin();
		case ($urandom_range(0, 9))
			0: return -1024;
			1: return 1023;
			2, 3: return int'($urandom_range(0, 2047)) - 1024;
			default: return int'($urandom_range(0, 48)) - 8;
		endcase
	endfunction

	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return $urandom_range(1025, 2047);
			3: return $urandom_range(2, 1024);
			default: return $urandom_range(2, 30);
		endcase
	endfunction

	function automatic int pick_grid_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(1, 2047);
			2: return 1024;
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	// Aim most cells at the selection box, some at the grid edges, the rest anywhere
	task automatic send_random_cell();
		int kind, col, row, pix;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			col = int'($urandom_range(0, cur_width + 3)) + cur_left - 2;
			row = int'($urandom_range(0, cur_height + 3)) + cur_top - 2;
		end else if (kind < 8) begin
			col = int'($urandom_range(0, cur_cols + 3)) - 2;
			row = int'($urandom_range(0, cur_rows + 3)) - 2;
		end else begin
			col = int'($urandom_range(0, (1 << CB) - 1)) + COORD_MIN;
			row = int'($urandom_range(0, (1 << CB) - 1)) + COORD_MIN;
		end
		pix = ($urandom_range(0, 3) == 0) ? int'(cur_trans) : int'($urandom_range(0, 255));
		send_cell(clamp_coord(col), clamp_coord(row), pix);
	endtask

	// Result receiver: segments of steady, random and sparse acceptance, plus one long hold
	initial begin
		int seg_left;
		int mode;
		result_ch.ready = 1'b0;
		seg_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (long_hold_armed && !long_hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				default: result_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Watchdog: stop the run when no transfer of any kind happens for too long
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cell_ch.valid && cell_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(psel && penable && pwrite && pready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cell_ch.valid = 1'b0;
		cell_ch.cell_col = '0;
		cell_ch.cell_row = '0;
		cell_ch.pixel_value = '0;
		burst_left = 0;
		steady_flow = 1'b0;
		long_hold_armed = 1'b0;
		long_hold_done = 1'b0;
		cells_sent = 0;
		settings_used = 1;
		cur_left = 0;
		cur_top = 0;
		cur_width = 0;
		cur_height = 0;
		cur_cols = 1024;
		cur_rows = 1024;
		cur_trans = 8'd0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty selection, coordinate extremes
		send_cell(COORD_MIN, COORD_MIN, 0);
		send_cell(COORD_MAX, COORD_MAX, 255);
		send_cell(0, 0, 8'h55);
		send_cell(-1, -1, 8'haa);
		settle();

		// widest rectangle straddling the grid, transparent at the top index
		set_selection(-1024, -1024, 2047, 2047, 0, 1024, 1024, 255);
		send_cell(-1024, -1024, 255);
		send_cell(0, 0, 255);
		send_cell(0, 0, 0);
		send_cell(1022, 1022, 7);
		send_cell(1023, 1023, 9);
		send_cell(1023, 0, 3);
		settle();

		// small ellipse: corners out, axis ends on the boundary
		set_selection(0, 0, 5, 3, 1, 1024, 1024, 0);
		send_cell(0, 0, 1);
		send_cell(2, 1, 2);
		send_cell(0, 1, 3);
		send_cell(4, 1, 0);
		send_cell(2, 0, 4);
		send_cell(1, 0, 5);
		settle();

		// one-wide ellipse on a grid of zero columns
		set_selection(5, -3, 1, 7, 1, 0, 1024, 17);
		send_cell(5, -3, 1);
		send_cell(5, 3, 17);
		send_cell(6, 0, 2);
		settle();

		// largest ellipse on an oversized grid
		set_selection(-1024, -1024, 2047, 2047, 1, 2047, 2047, 0);
		send_cell(-1024, 0, 9);
		send_cell(0, 0, 0);
		send_cell(1022, 1022, 200);
		send_cell(COORD_MAX, COORD_MIN, 1);
		settle();

		// random settings, each followed by a burst of cells aimed at them
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_selection(pick_origin(), pick_origin(), pick_extent(), pick_extent(),
				$urandom_range(0, 1), pick_grid_size(), pick_grid_size(), $urandom_range(0, 255));
			steady_flow = (phase == 2);
			if (phase == 0)
				long_hold_armed = 1'b1;
			repeat (PHASE_CELLS) send_random_cell();
			settle();
		end

		$display("%0d cells over %0d register settings: rectangle, ellipse, empty, thin",
			cells_sent, settings_used);
		$display("selections and zero or oversized grids; %0d classified, %0d inside the mask",
			checked_count, mask_count);
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
